/* rtl/lkh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkh_pkg - shared types and constants of the byte-stream lookup3 hash
// Payload types of the request, queue and response channels, the hash
// constants and the back end state type.
// ----------------------------------------------------------------------------
package lkh_pkg;

   localparam logic [31:0] SEED_BASE           = 32'hdeadbeef;
   localparam int          BLOCK_BYTES         = 12;
   localparam int          QUEUE_DEPTH_DEFAULT = 4;

   // request beat: one key byte
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [31:0] key_length;
   } lkh_req_type;

   // response beat: the finalized words, or the seed for an empty key
   typedef struct packed {
      logic [31:0] hash_c;
      logic [31:0] hash_b;
      logic [31:0] hash_a;
   } lkh_rsp_type;

   // classified work item between front and back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [3:0]  byte_pos;   // place within the 12-byte block
      logic        start;      // reload the words from seed first
      logic        empty;      // empty key: emit the seed as is
      logic        last;       // run the final rounds and emit
      logic        mix;        // block complete, more bytes follow
      logic [31:0] seed;
   } lkh_entry_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_MIX,
      BK_FINAL
   } lkh_back_state_type;

endpackage

/* rtl/lkh_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkh_stream_if - valid/ready channel
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lkh_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/lkh_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkh_front - request intake and classification
// Holds the init value register and the block position, computes the seed
// and tags each beat with its byte lane, mix and finish flags.
// ----------------------------------------------------------------------------
module lkh_front (
   input  logic         clock,
   input  logic         reset,
   lkh_stream_if.sink   req_if,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   lkh_stream_if.source push_if
);
   import lkh_pkg::*;

   localparam logic [3:0] LAST_POS = 4'(BLOCK_BYTES - 1);

   logic [31:0]   init_value_ff;
   logic [31:0]   init_value_in;
   logic [3:0]    pos_ff;
   logic [3:0]    pos_in;
   logic [3:0]    pos_cur;
   logic          empty_key;
   lkh_req_type   req;
   lkh_entry_type entry;
   logic          accept;

   assign req    = req_if.payload;
   assign accept = req_if.valid && push_if.ready;

   // config register
   assign init_value_in = csr_wr_en ? csr_wr_data : init_value_ff;

   // classify the beat
   always_comb begin
      pos_cur   = req.first_byte ? 4'd0 : pos_ff;
      empty_key = req.first_byte && (req.key_length == 32'd0);

      entry.data_byte = req.data_byte;
      entry.byte_pos  = pos_cur;
      entry.start     = req.first_byte;
      entry.empty     = empty_key;
      entry.last      = req.last_byte && !empty_key;
      entry.mix       = !empty_key && !req.last_byte && (pos_cur == LAST_POS);
      entry.seed      = SEED_BASE + req.key_length + init_value_ff;

      pos_in = pos_ff;
      if (accept) begin
         if (empty_key || req.last_byte || pos_cur == LAST_POS) begin
            pos_in = 4'd0;
         end else begin
            pos_in = pos_cur + 4'd1;
         end
      end
   end

   assign push_if.valid   = req_if.valid;
   assign push_if.payload = entry;
   assign req_if.ready    = push_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_value_ff <= '0;
         pos_ff        <= '0;
      end else begin
         init_value_ff <= init_value_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

/* rtl/lkh_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkh_queue - work queue between front and back
// Small circular buffer of classified beats; lets the front keep taking
// bytes while the back runs mix or final rounds.
// ----------------------------------------------------------------------------
module lkh_queue #(
   parameter int DEPTH = lkh_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   lkh_stream_if.sink   push_if,
   lkh_stream_if.source pop_if
);
   import lkh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lkh_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_if.ready  = (count_ff != CNT_FULL);
   assign pop_if.valid   = (count_ff != '0);
   assign pop_if.payload = slot_ff[head_ff];

   assign do_push = push_if.valid && push_if.ready;
   assign do_pop  = pop_if.valid && pop_if.ready;

   // pointer and fill count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= push_if.payload;
      end
   end

endmodule

/* rtl/lkh_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkh_back - hash word datapath
// Adds each byte into a, b or c, runs six mix and seven final steps one per
// cycle, the last waiting for a free output, and holds the response register.
// ----------------------------------------------------------------------------
module lkh_back (
   input  logic         clock,
   input  logic         reset,
   lkh_stream_if.sink   pop_if,
   lkh_stream_if.source rsp_if
);
   import lkh_pkg::*;

   localparam logic [2:0] MIX_LAST   = 3'd5;
   localparam logic [2:0] FINAL_LAST = 3'd6;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } lkh_words_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
      return (x << k) | (x >> (32 - k));
   endfunction

   // one line of the mix: subtract, xor rotated, add into the next word
   function automatic lkh_words_type mix_step(input lkh_words_type w, input logic [2:0] r);
      lkh_words_type o;
      o = w;
      unique case (r)
         3'd0: begin o.a = (w.a - w.c) ^ rotl32(w.c, 4);  o.c = w.c + w.b; end
         3'd1: begin o.b = (w.b - w.a) ^ rotl32(w.a, 6);  o.a = w.a + w.c; end
         3'd2: begin o.c = (w.c - w.b) ^ rotl32(w.b, 8);  o.b = w.b + w.a; end
         3'd3: begin o.a = (w.a - w.c) ^ rotl32(w.c, 16); o.c = w.c + w.b; end
         3'd4: begin o.b = (w.b - w.a) ^ rotl32(w.a, 19); o.a = w.a + w.c; end
         default: begin o.c = (w.c - w.b) ^ rotl32(w.b, 4); o.b = w.b + w.a; end
      endcase
      return o;
   endfunction

   // one line of the finalization: xor, subtract rotated
   function automatic lkh_words_type final_step(input lkh_words_type w, input logic [2:0] r);
      lkh_words_type o;
      o = w;
      unique case (r)
         3'd0: o.c = (w.c ^ w.b) - rotl32(w.b, 14);
         3'd1: o.a = (w.a ^ w.c) - rotl32(w.c, 11);
         3'd2: o.b = (w.b ^ w.a) - rotl32(w.a, 25);
         3'd3: o.c = (w.c ^ w.b) - rotl32(w.b, 16);
         3'd4: o.a = (w.a ^ w.c) - rotl32(w.c, 4);
         3'd5: o.b = (w.b ^ w.a) - rotl32(w.a, 14);
         default: o.c = (w.c ^ w.b) - rotl32(w.b, 24);
      endcase
      return o;
   endfunction

   lkh_back_state_type state_ff, state_in;
   logic [2:0]         round_ff, round_in;
   lkh_words_type      words_ff, words_in;
   lkh_words_type      base;
   lkh_words_type      stepped;
   logic               rsp_valid_ff, rsp_valid_in;
   lkh_rsp_type        rsp_data_ff, rsp_data_in;
   lkh_entry_type      entry;
   logic               out_free;
   logic               load_out;
   logic [31:0]        shifted;

   assign entry    = pop_if.payload;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      unique case (state_ff)
         BK_RUN: begin
            if (pop_if.valid && !entry.empty) begin
               round_in = 3'd0;
               if (entry.last) begin
                  state_in = BK_FINAL;
               end else if (entry.mix) begin
                  state_in = BK_MIX;
               end
            end
         end
         BK_MIX: begin
            if (round_ff == MIX_LAST) begin
               state_in = BK_RUN;
            end else begin
               round_in = round_ff + 3'd1;
            end
         end
         BK_FINAL: begin
            if (round_ff != FINAL_LAST) begin
               round_in = round_ff + 3'd1;
            end else if (out_free) begin
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      words_in      = words_ff;
      load_out      = 1'b0;
      pop_if.ready  = 1'b0;
      base          = entry.start
                      ? lkh_words_type'{a: entry.seed, b: entry.seed, c: entry.seed}
                      : words_ff;
      shifted       = {24'd0, entry.data_byte} << {entry.byte_pos[1:0], 3'b000};
      stepped       = words_ff;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         BK_RUN: begin
            pop_if.ready = !entry.empty || out_free;
            if (pop_if.valid && entry.empty) begin
               if (out_free) begin
                  words_in = '{a: entry.seed, b: entry.seed, c: entry.seed};
                  load_out = 1'b1;
               end
            end else if (pop_if.valid) begin
               // little-endian byte lane into a, b or c
               words_in = base;
               unique case (entry.byte_pos[3:2])
                  2'd0:    words_in.a = base.a + shifted;
                  2'd1:    words_in.b = base.b + shifted;
                  default: words_in.c = base.c + shifted;
               endcase
            end
         end
         BK_MIX: begin
            words_in = mix_step(words_ff, round_ff);
         end
         BK_FINAL: begin
            stepped = final_step(words_ff, round_ff);
            if (round_ff != FINAL_LAST) begin
               words_in = stepped;
            end else if (out_free) begin
               words_in = stepped;
               load_out = 1'b1;
            end
         end
         default: begin
            words_in = words_ff;
         end
      endcase

      if (load_out) begin
         rsp_data_in = '{hash_c: words_in.c, hash_b: words_in.b, hash_a: words_in.a};
      end
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_if.ready);
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         round_ff     <= '0;
         words_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         words_ff     <= words_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/lookup3_byte_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookup3_byte_hash - lookup3 little-endian hash of a byte-serial key
// Request channel req_if carries one key byte per beat with first/last
// marks and the key length (read on the first beat). Response channel
// rsp_if carries hash_c, hash_b, hash_a once per key. csr_wr_en/csr_wr_data
// write the init value; the user must write it only while the block is idle,
// the block itself does not enforce it. Bytes are taken one per cycle while
// the queue has room. The back runs the mix steps, one per cycle on the word
// datapath, after each full 12-byte block that more bytes follow, and the
// final steps once per key. The front queue (QUEUE_DEPTH beats) keeps taking
// bytes while the back runs these steps. An empty key goes from the queue
// straight to the response register; a last byte goes after the final steps.
// Reset clears the words, the block position, the init value, the queue and
// the response valid flag. When the receiver stalls, the response register
// holds; the back waits at its last final step and the queue fills, then
// req_if.ready drops.
// ----------------------------------------------------------------------------
module lookup3_byte_hash #(
   parameter int QUEUE_DEPTH = lkh_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   lkh_stream_if.sink   req_if,
   lkh_stream_if.source rsp_if,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);
   import lkh_pkg::*;

   lkh_stream_if #(.payload_type(lkh_entry_type)) push_ch ();
   lkh_stream_if #(.payload_type(lkh_entry_type)) pop_ch ();

   // intake and classification
   lkh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_if     (push_ch.source)
   );

   // decoupling queue
   lkh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_if (push_ch.sink),
      .pop_if  (pop_ch.source)
   );

   // hash datapath and response register
   lkh_back u_back (
      .clock  (clock),
      .reset  (reset),
      .pop_if (pop_ch.sink),
      .rsp_if (rsp_if)
   );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the byte-stream lookup3 hash
// Streams keys into lookup3_byte_hash one byte per beat and checks every
// response beat against hash words worked out in the testbench itself.
// A directed part covers the edge cases; random phases follow, each with
// its own init value. The sender idles in bursts and the receiver stalls
// in changing patterns.
// ----------------------------------------------------------------------------
module tb;
   import lkh_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 48;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_BEATS = 215;

   typedef enum logic [1:0] {
      RSP_OPEN,
      RSP_JITTER,
      RSP_SPARSE,
      RSP_LONG_STALL
   } rsp_mode_type;

   // running hash words and the queue of hashes still owed by the block
   class lookup3_score;
      logic [31:0] init_value;
      logic [31:0] wa, wb, wc;
      int          pos;
      lkh_rsp_type hash_queue[$];
      int          mismatches;

      function new();
         init_value = '0;
         wa = '0;
         wb = '0;
         wc = '0;
         pos = 0;
         mismatches = 0;
      endfunction

      function logic [31:0] rot(logic [31:0] x, int k);
         return (x << k) | (x >> (32 - k));
      endfunction

      function void mix_words();
         wa -= wc; wa ^= rot(wc, 4);  wc += wb;
         wb -= wa; wb ^= rot(wa, 6);  wa += wc;
         wc -= wb; wc ^= rot(wb, 8);  wb += wa;
         wa -= wc; wa ^= rot(wc, 16); wc += wb;
         wb -= wa; wb ^= rot(wa, 19); wa += wc;
         wc -= wb; wc ^= rot(wb, 4);  wb += wa;
      endfunction

      function void final_words();
         wc ^= wb; wc -= rot(wb, 14);
         wa ^= wc; wa -= rot(wc, 11);
         wb ^= wa; wb -= rot(wa, 25);
         wc ^= wb; wc -= rot(wb, 16);
         wa ^= wc; wa -= rot(wc, 4);
         wb ^= wa; wb -= rot(wa, 14);
         wc ^= wb; wc -= rot(wb, 24);
      endfunction

      function void push_words();
         lkh_rsp_type h;
         h.hash_c = wc;
         h.hash_b = wb;
         h.hash_a = wa;
         hash_queue.push_back(h);
      endfunction

      // fold one accepted request beat into the words
      function void take_byte(lkh_req_type r);
         logic [31:0] seed;
         logic [31:0] shifted;
         if (r.first_byte) begin
            seed = SEED_BASE + r.key_length + init_value;
            wa = seed;
            wb = seed;
            wc = seed;
            pos = 0;
            // empty key: seed goes out as is
            if (r.key_length == 0) begin
               push_words();
               return;
            end
         end
         shifted = {24'd0, r.data_byte} << (8 * (pos % 4));
         if (pos < 4) wa += shifted;
         else if (pos < 8) wb += shifted;
         else wc += shifted;
         pos++;
         if (r.last_byte) begin
            final_words();
            pos = 0;
            push_words();
            return;
         end
         if (pos == BLOCK_BYTES) begin
            mix_words();
            pos = 0;
         end
      endfunction

      function void check_hash(lkh_rsp_type got);
         lkh_rsp_type want;
         if (hash_queue.size() == 0) begin
            $error("hash beat with none owed: %h %h %h", got.hash_c, got.hash_b, got.hash_a);
            mismatches++;
            return;
         end
         want = hash_queue.pop_front();
         if (got.hash_c !== want.hash_c) begin
            $error("hash_c: expected %h, got %h", want.hash_c, got.hash_c);
            mismatches++;
         end
         if (got.hash_b !== want.hash_b) begin
            $error("hash_b: expected %h, got %h", want.hash_b, got.hash_b);
            mismatches++;
         end
         if (got.hash_a !== want.hash_a) begin
            $error("hash_a: expected %h, got %h", want.hash_a, got.hash_a);
            mismatches++;
         end
      endfunction

      function int pending();
         return hash_queue.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   lkh_stream_if #(.payload_type(lkh_req_type)) req_ch ();
   lkh_stream_if #(.payload_type(lkh_rsp_type)) rsp_ch ();

   lookup3_score score;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           beats_sent = 0;
   logic [7:0]   rsp_tick = '0;
   rsp_mode_type rsp_mode = RSP_OPEN;

   lookup3_byte_hash dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) score.take_byte(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) score.check_hash(rsp_ch.payload);
      end
   end

   // receiver: stall pattern changes each time rsp_tick wraps
   always @(posedge clock) begin
      rsp_tick <= rsp_tick + 8'd1;
      if (rsp_tick == 8'd0) rsp_mode <= rsp_mode_type'($urandom_range(0, 3));
      case (rsp_mode)
         RSP_OPEN:   rsp_ch.ready <= 1'b1;
         RSP_JITTER: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         RSP_SPARSE: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         default:    rsp_ch.ready <= (rsp_tick[4:0] >= 5'd22);
      endcase
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one request beat; bursts of random length with random gaps between
   task automatic send_beat(input logic [7:0] data, input logic first, input logic last,
                            input logic [31:0] len);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= '{data_byte: data, first_byte: first, last_byte: last,
                          key_length: len};
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      beats_sent++;
   endtask

   // a key of nbytes bytes; all_ones fills it with 0xff
   task automatic send_key(input int nbytes, input logic [31:0] len, input bit with_last,
                           input bit all_ones);
      logic [7:0] data;
      for (int i = 0; i < nbytes; i++) begin
         data = all_ones ? 8'hff : 8'($urandom_range(0, 255));
         send_beat(data, i == 0, with_last && (i == nbytes - 1),
                   (i == 0) ? len : $urandom);
      end
   endtask

   // stop sending and let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (score.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_init(input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      score.init_value = value;
   endtask

   // main sequence
   initial begin
      int pick;
      int nbytes;
      logic [31:0] len;
      score = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // bytes with no start: on the zero words, then on a finished hash
      send_beat(8'hff, 1'b0, 1'b1, $urandom);
      send_beat(8'h00, 1'b0, 1'b1, $urandom);
      // empty keys, with and without the last mark
      send_beat(8'ha5, 1'b1, 1'b0, 32'd0);
      send_beat(8'h5a, 1'b1, 1'b1, 32'd0);
      // single-byte key
      send_beat(8'h00, 1'b1, 1'b1, 32'd1);
      // one full block plus one byte, length field at its top
      send_key(13, 32'hffffffff, 1'b1, 1'b1);
      // length field that disagrees with the marks
      send_key(2, 32'd7, 1'b1, 1'b0);
      drain();
      write_init(32'hffffffff);
      send_key(5, 32'd5, 1'b1, 1'b1);
      drain();

      // random phases, each under its own init value
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_init((phase == 0) ? 32'd0 : (phase == 1) ? 32'hffffffff : $urandom);
         beats_sent = 0;
         while (beats_sent < PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               // well-formed key, mostly short
               pick = $urandom_range(0, 9);
               if (pick < 7) nbytes = $urandom_range(1, 14);
               else if (pick < 9) nbytes = $urandom_range(15, 40);
               else begin
                  case ($urandom_range(0, 6))
                     0: nbytes = 11;
                     1: nbytes = 12;
                     2: nbytes = 13;
                     3: nbytes = 23;
                     4: nbytes = 24;
                     5: nbytes = 25;
                     default: nbytes = 36;
                  endcase
               end
               len = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
               send_key(nbytes, len, 1'b1, 1'b0);
            end else if (pick < 88) begin
               send_beat(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)), 32'd0);
            end else if (pick < 95) begin
               // abandoned key, cut off by whatever comes next
               nbytes = $urandom_range(1, 20);
               send_key(nbytes, nbytes, 1'b0, 1'b0);
            end else begin
               // noise beats
               repeat ($urandom_range(1, 4)) begin
                  len = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
                  send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), len);
               end
            end
         end
         // close any open key so the phase ends idle
         send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, $urandom);
         drain();
      end

      if (score.mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
